>>> design/rsr_pkg.sv
// ----------------------------------------------------------------------------
// rsr_pkg
// types, codes and field widths shared by the rename slot ring files
// ----------------------------------------------------------------------------
package rsr_pkg;

   localparam int SIZE_W      = 27;
   localparam int IDX_FIELD_W = 4;
   localparam int SEQ_W       = 32;
   localparam int RING_W      = 4;
   localparam int RES_W       = 32;
   localparam int OFF_W       = 32;
   localparam int CHOSEN_W    = 3;
   localparam int ACTIVE_W    = 4;

   typedef enum logic [1:0] {
      OP_ROTATE   = 2'd0,
      OP_SUBMIT   = 2'd1,
      OP_ADD_SLOT = 2'd2,
      OP_RELEASE  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK           = 2'd0,
      STATUS_REJECT       = 2'd1,
      STATUS_POOL_REFUSED = 2'd2
   } status_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } state_type;

   typedef struct packed {
      op_type                 opcode;
      logic [IDX_FIELD_W-1:0] slot_index;
      logic [SEQ_W-1:0]       seqno;
      logic [RING_W-1:0]      ring_id;
      logic                   pool_ok;
      logic [RES_W-1:0]       pool_res_id;
      logic [OFF_W-1:0]       pool_offset;
   } req_type;

   typedef struct packed {
      logic [CHOSEN_W-1:0] chosen_slot;
      logic                grew;
      logic                must_wait;
      logic [SEQ_W-1:0]    wait_seqno;
      logic [RING_W-1:0]   wait_ring;
      logic [RES_W-1:0]    slot_res_id;
      logic [OFF_W-1:0]    slot_offset;
      status_type          status;
      logic [ACTIVE_W-1:0] active_slots;
   } rsp_type;

endpackage

>>> design/rsr_if.sv
// ----------------------------------------------------------------------------
// rsr channel interfaces
// valid/ready channels for requests, responses and the slot size register
// ----------------------------------------------------------------------------
interface rsr_req_if;
   logic             valid;
   logic             ready;
   rsr_pkg::req_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface rsr_rsp_if;
   logic             valid;
   logic             ready;
   rsr_pkg::rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface rsr_csr_if;
   logic                        valid;
   logic                        ready;
   logic [rsr_pkg::SIZE_W-1:0]  data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

>>> design/rsr_ram.sv
// ----------------------------------------------------------------------------
// rsr_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module rsr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/rename_slot_ring.sv
// ----------------------------------------------------------------------------
// rename_slot_ring
// ring of staging slots that a producer rotates through, with fence waits
// ----------------------------------------------------------------------------
//
//  channel   direction  transfer moves
//  --------  ---------  ------------------------------------------------
//  req_if    in         one operation: rotate, submit, add_slot, release
//  rsp_if    out        one result per operation
//  csr_if    in         slot size register write (bytes per slot)
//
//  each item is read from both slot memories in its transfer cycle; in exec
//  the block updates state, writes back and loads the output register;
//  no new item is taken until the last one completes its write-back
//  reset clears control flops only; the memories are not swept
//  a full output register holds the item in exec until taken
//
module rename_slot_ring #(
   parameter int MAX_SLOTS = 8
) (
   input  logic    clock,
   input  logic    reset,
   rsr_req_if.sink   req_if,
   rsr_rsp_if.source rsp_if,
   rsr_csr_if.sink   csr_if
);

   localparam int IDX_W   = $clog2(MAX_SLOTS);
   localparam int CNT_W   = $clog2(MAX_SLOTS + 1);
   localparam int SLOT_W  = rsr_pkg::RES_W + rsr_pkg::OFF_W;
   localparam int FENCE_W = rsr_pkg::SEQ_W + rsr_pkg::RING_W;
   localparam int EXT_W   = rsr_pkg::IDX_FIELD_W + 1;

   // control state
   rsr_pkg::state_type          state_ff, state_in;
   logic [rsr_pkg::SIZE_W-1:0]  size_ff;
   logic [MAX_SLOTS-1:0]        valid_ff, valid_in;
   logic [MAX_SLOTS-1:0]        busy_ff, busy_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic [IDX_W-1:0]            cur_ff, cur_in;
   logic                        size_clr;

   // item held from its transfer until it completes, and the output register
   rsr_pkg::req_type            item_ff;
   logic                        rsp_valid_ff;
   rsr_pkg::rsp_type            rsp_data_ff, rsp_in;

   logic                        req_xfer, exec_done;

   // memory ports
   logic [IDX_W-1:0]            rd_addr;
   logic                        slot_we, fence_we;
   logic [IDX_W-1:0]            slot_waddr, fence_waddr;
   logic [SLOT_W-1:0]           slot_rd;
   logic [FENCE_W-1:0]          fence_rd;

   // wrap-around next slot, a compare and not a divide
   logic [IDX_W:0]              nxt_sum;
   logic [IDX_W-1:0]            nxt;

   always_comb begin
      nxt_sum = {1'b0, cur_ff} + {{IDX_W{1'b0}}, 1'b1};
      if (count_ff == '0) begin
         nxt = '0;
      end else if ((CNT_W + 1)'(nxt_sum) >= (CNT_W + 1)'(count_ff)) begin
         nxt = '0;
      end else begin
         nxt = nxt_sum[IDX_W-1:0];
      end
   end

   // --------------------------------------------------------------------
   // state machine: idle takes an item, exec finishes it
   // --------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rsr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      req_if.ready = 1'b0;
      exec_done    = 1'b0;
      unique case (state_ff)
         rsr_pkg::ST_IDLE: begin
            req_if.ready = 1'b1;
            if (req_if.valid) begin
               state_in = rsr_pkg::ST_EXEC;
            end
         end
         rsr_pkg::ST_EXEC: begin
            // output register free or emptying this cycle
            if (!rsp_valid_ff || rsp_if.ready) begin
               exec_done = 1'b1;
               state_in  = rsr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rsr_pkg::ST_IDLE;
         end
      endcase
   end

   assign req_xfer = req_if.valid && req_if.ready;

   // --------------------------------------------------------------------
   // read address for the transfer cycle
   // --------------------------------------------------------------------
   logic                        req_idx_ok;

   assign req_idx_ok = ({1'b0, req_if.data.slot_index} < EXT_W'(MAX_SLOTS));

   always_comb begin
      if (req_if.data.opcode == rsr_pkg::OP_ROTATE) begin
         rd_addr = nxt;
      end else if (req_idx_ok) begin
         rd_addr = req_if.data.slot_index[IDX_W-1:0];
      end else begin
         rd_addr = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         item_ff <= req_if.data;
      end
   end

   // resource id and pool offset of each slot
   rsr_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (MAX_SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_we),
      .wr_addr (slot_waddr),
      .wr_data ({item_ff.pool_res_id, item_ff.pool_offset}),
      .rd_en   (req_xfer),
      .rd_addr (rd_addr),
      .rd_data (slot_rd)
   );

   // pending fence and ring of each slot
   rsr_ram #(
      .WIDTH (FENCE_W),
      .DEPTH (MAX_SLOTS)
   ) u_fence_ram (
      .clock   (clock),
      .wr_en   (fence_we),
      .wr_addr (fence_waddr),
      .wr_data ({item_ff.seqno, item_ff.ring_id}),
      .rd_en   (req_xfer),
      .rd_addr (rd_addr),
      .rd_data (fence_rd)
   );

   // --------------------------------------------------------------------
   // second state, exec: decide, update, build the result
   // --------------------------------------------------------------------
   logic                        idx_ok;
   logic [IDX_W-1:0]            idx_sel;
   logic [CNT_W-1:0]            idx_cnt;
   logic [IDX_W-1:0]            cnt_idx;
   logic                        below_max;
   logic [IDX_W-1:0]            chosen;
   logic                        use_pool, use_mem;

   assign idx_ok    = ({1'b0, item_ff.slot_index} < EXT_W'(MAX_SLOTS));
   assign idx_sel   = item_ff.slot_index[IDX_W-1:0];
   assign idx_cnt   = CNT_W'(idx_sel) + CNT_W'(1);
   assign cnt_idx   = count_ff[IDX_W-1:0];
   assign below_max = (count_ff < CNT_W'(MAX_SLOTS));

   always_comb begin
      chosen      = '0;
      use_pool    = 1'b0;
      use_mem     = 1'b0;
      valid_in    = valid_ff;
      busy_in     = busy_ff;
      count_in    = count_ff;
      cur_in      = cur_ff;
      size_clr    = 1'b0;
      slot_we     = 1'b0;
      slot_waddr  = idx_sel;
      fence_we    = 1'b0;
      fence_waddr = idx_sel;
      rsp_in      = '0;
      rsp_in.status = rsr_pkg::STATUS_OK;

      unique case (item_ff.opcode)
         rsr_pkg::OP_ROTATE: begin
            if (size_ff == '0) begin
               // ring unconfigured
               rsp_in.status = rsr_pkg::STATUS_REJECT;
            end else begin
               if (count_ff != '0 && !busy_ff[nxt]) begin
                  chosen  = nxt;
                  use_mem = valid_ff[nxt];
               end else if (below_max && item_ff.pool_ok) begin
                  // grow by one slot at the end of the table
                  chosen            = cnt_idx;
                  valid_in[cnt_idx] = 1'b1;
                  busy_in[cnt_idx]  = 1'b0;
                  count_in          = count_ff + CNT_W'(1);
                  slot_we           = 1'b1;
                  slot_waddr        = cnt_idx;
                  use_pool          = 1'b1;
                  rsp_in.grew       = 1'b1;
               end else begin
                  // no growth: reuse next slot, waiting on its fence if it is busy
                  if (below_max) begin
                     rsp_in.status = rsr_pkg::STATUS_POOL_REFUSED;
                  end
                  if (busy_ff[nxt]) begin
                     rsp_in.must_wait  = 1'b1;
                     rsp_in.wait_seqno = fence_rd[FENCE_W-1:rsr_pkg::RING_W];
                     rsp_in.wait_ring  = fence_rd[rsr_pkg::RING_W-1:0];
                     busy_in[nxt]      = 1'b0;
                  end
                  chosen  = nxt;
                  use_mem = valid_ff[nxt];
               end
               cur_in = chosen;
            end
         end
         rsr_pkg::OP_SUBMIT: begin
            if (!idx_ok) begin
               rsp_in.status = rsr_pkg::STATUS_REJECT;
            end else begin
               fence_we         = 1'b1;
               busy_in[idx_sel] = 1'b1;
               chosen           = idx_sel;
               use_mem          = valid_ff[idx_sel];
            end
         end
         rsr_pkg::OP_ADD_SLOT: begin
            if (size_ff == '0 || !idx_ok) begin
               rsp_in.status = rsr_pkg::STATUS_REJECT;
            end else begin
               chosen = idx_sel;
               if (valid_ff[idx_sel]) begin
                  use_mem = 1'b1;
               end else if (item_ff.pool_ok) begin
                  valid_in[idx_sel] = 1'b1;
                  busy_in[idx_sel]  = 1'b0;
                  if (idx_cnt > count_ff) begin
                     count_in = idx_cnt;
                  end
                  slot_we     = 1'b1;
                  slot_waddr  = idx_sel;
                  use_pool    = 1'b1;
                  rsp_in.grew = 1'b1;
               end else begin
                  rsp_in.status = rsr_pkg::STATUS_POOL_REFUSED;
               end
            end
         end
         rsr_pkg::OP_RELEASE: begin
            // an empty table is left as it is
            if (count_ff != '0) begin
               valid_in = '0;
               busy_in  = '0;
               count_in = '0;
               cur_in   = '0;
               size_clr = 1'b1;
            end
         end
         default: begin
            rsp_in.status = rsr_pkg::STATUS_OK;
         end
      endcase

      if (use_pool) begin
         rsp_in.slot_res_id = item_ff.pool_res_id;
         rsp_in.slot_offset = item_ff.pool_offset;
      end else if (use_mem) begin
         rsp_in.slot_res_id = slot_rd[SLOT_W-1:rsr_pkg::OFF_W];
         rsp_in.slot_offset = slot_rd[rsr_pkg::OFF_W-1:0];
      end
      rsp_in.chosen_slot  = rsr_pkg::CHOSEN_W'(chosen);
      rsp_in.active_slots = rsr_pkg::ACTIVE_W'(count_in);

      // memories written only as the item completes
      if (!exec_done) begin
         slot_we  = 1'b0;
         fence_we = 1'b0;
      end
   end

   // --------------------------------------------------------------------
   // control registers
   // --------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         busy_ff  <= '0;
         count_ff <= '0;
         cur_ff   <= '0;
      end else if (exec_done) begin
         valid_ff <= valid_in;
         busy_ff  <= busy_in;
         count_ff <= count_in;
         cur_ff   <= cur_in;
      end
   end

   // slot size register; the user writes it only while idle, the block does not enforce this
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= '0;
      end else if (csr_if.valid && csr_if.ready) begin
         size_ff <= csr_if.data;
      end else if (exec_done && size_clr) begin
         size_ff <= '0;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (exec_done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (exec_done) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.data  = rsp_data_ff;

   // --------------------------------------------------------------------
   // assertions
   // --------------------------------------------------------------------
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_SLOTS))
      else $error("slot count above cap");

   a_valid_below_count: assert property (@(posedge clock) disable iff (reset)
      (valid_ff >> count_ff) == '0)
      else $error("valid slot at or above slot count");

   a_cur_in_table: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) |-> (CNT_W'(cur_ff) < count_ff))
      else $error("current slot outside table");

   a_wr_in_exec: assert property (@(posedge clock) disable iff (reset)
      (slot_we || fence_we) |-> (state_ff == rsr_pkg::ST_EXEC))
      else $error("slot memory written outside exec");

   a_no_read_in_exec: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rsr_pkg::ST_EXEC) |-> !req_xfer)
      else $error("request taken while an item is in flight");

endmodule

>>> dv/rename_slot_ring_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rename_slot_ring_tb
// drives operations into the slot ring, predicts every result with an
// independent model of the slot table and checks each response in order
// ----------------------------------------------------------------------------
module rename_slot_ring_tb;

   localparam int          MAX_SLOTS    = 8;
   localparam int          CLK_HALF     = 10;
   localparam int          RESET_CYCLES = 12;
   localparam int          RANDOM_ITEMS = 400;
   localparam int          MAX_GAP      = 19;
   localparam int          HOLD_AT      = 150;
   localparam int          HOLD_CYCLES  = 400;
   localparam int          DRAIN_CYCLES = 4;
   localparam int          TAIL_CYCLES  = 8;
   localparam int          SHOW_LIMIT   = 10;
   localparam longint      TIMEOUT_NS   = 4_000_000;
   localparam logic [rsr_pkg::SIZE_W-1:0] SIZE_MIN = 27'd64;
   localparam logic [rsr_pkg::SIZE_W-1:0] SIZE_MAX = 27'd67108864;

   // one row of the directed table
   typedef struct {
      bit                         load_size;   // write the size register before this row
      logic [rsr_pkg::SIZE_W-1:0] size_val;
      rsr_pkg::req_type           req;
      bit                         fixed;       // expected result typed in below
      rsr_pkg::rsp_type           rsp;
   } step_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rsr_req_if req_ch ();
   rsr_rsp_if rsp_ch ();
   rsr_csr_if csr_ch ();

   rename_slot_ring #(
      .MAX_SLOTS (MAX_SLOTS)
   ) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   always #(CLK_HALF) clock = ~clock;

   // ---------------------------------------------------------------------
   // slot table shadow, updated once per accepted request
   // ---------------------------------------------------------------------
   logic [rsr_pkg::SIZE_W-1:0] cur_size = '0;
   bit                         slot_live     [MAX_SLOTS];
   logic [rsr_pkg::RES_W-1:0]  slot_owner    [MAX_SLOTS];
   logic [rsr_pkg::OFF_W-1:0]  slot_addr     [MAX_SLOTS];
   bit                         slot_inflight [MAX_SLOTS];
   logic [rsr_pkg::SEQ_W-1:0]  slot_seq      [MAX_SLOTS];
   logic [rsr_pkg::RING_W-1:0] slot_ringno   [MAX_SLOTS];
   int unsigned                live_count = 0;
   int unsigned                cursor     = 0;

   rsr_pkg::rsp_type pending_rsp [$];   // expected responses, oldest first
   int      error_count = 0;
   int      shown_count = 0;
   bit      quiet_phase = 1'b0; // no random idling on either side while set; the long hold-off still applies

   // bring slot s into use from the pool grant; returns 1 if it is live after
   function automatic bit grant_slot(input int unsigned s, input rsr_pkg::req_type r,
                                     output bit fresh);
      fresh = 1'b0;
      if (slot_live[s]) return 1'b1;
      if (!r.pool_ok) return 1'b0;
      slot_live[s]     = 1'b1;
      slot_owner[s]    = r.pool_res_id;
      slot_addr[s]     = r.pool_offset;
      slot_seq[s]      = '0;
      slot_ringno[s]   = '0;
      slot_inflight[s] = 1'b0;
      if (s + 1 > live_count) live_count = s + 1;
      fresh = 1'b1;
      return 1'b1;
   endfunction

   // result of one request, with the side effects on the shadow table
   function automatic rsr_pkg::rsp_type predict_slot_result(input rsr_pkg::req_type r);
      rsr_pkg::rsp_type o;
      int unsigned idx;
      int unsigned cnt;
      int unsigned nxt;
      int unsigned chosen;
      bit          reject;
      bit          fresh;
      o      = '0;
      idx    = r.slot_index;
      chosen = 0;
      reject = 1'b0;
      fresh  = 1'b0;
      case (r.opcode)
         rsr_pkg::OP_ROTATE: begin
            if (cur_size == 0) begin
               reject = 1'b1;
            end else begin
               cnt = live_count;
               nxt = 0;
               // wrap by compare
               if (cnt != 0) begin
                  nxt = cursor + 1;
                  if (nxt >= cnt) nxt = 0;
               end
               if (cnt != 0 && !slot_inflight[nxt]) begin
                  chosen = nxt;
               end else if (cnt < MAX_SLOTS && grant_slot(cnt, r, fresh)) begin
                  chosen = cnt;
               end else begin
                  if (cnt < MAX_SLOTS) o.status = rsr_pkg::STATUS_POOL_REFUSED;
                  // wait path: hand out the fence, keep the sequence number
                  if (slot_inflight[nxt]) begin
                     o.must_wait        = 1'b1;
                     o.wait_seqno       = slot_seq[nxt];
                     o.wait_ring        = slot_ringno[nxt];
                     slot_inflight[nxt] = 1'b0;
                     slot_ringno[nxt]   = '0;
                  end
                  chosen = nxt;
               end
               cursor = chosen;
            end
         end
         rsr_pkg::OP_SUBMIT: begin
            if (idx >= MAX_SLOTS) begin
               reject = 1'b1;
            end else begin
               slot_seq[idx]      = r.seqno;
               slot_ringno[idx]   = r.ring_id;
               slot_inflight[idx] = 1'b1;
               chosen             = idx;
            end
         end
         rsr_pkg::OP_ADD_SLOT: begin
            if (cur_size == 0 || idx >= MAX_SLOTS) begin
               reject = 1'b1;
            end else begin
               chosen = idx;
               if (!grant_slot(idx, r, fresh)) o.status = rsr_pkg::STATUS_POOL_REFUSED;
            end
         end
         rsr_pkg::OP_RELEASE: begin
            if (live_count != 0) begin
               for (int i = 0; i < MAX_SLOTS; i++) begin
                  slot_live[i]     = 1'b0;
                  slot_owner[i]    = '0;
                  slot_inflight[i] = 1'b0;
                  slot_ringno[i]   = '0;
               end
               live_count = 0;
               cur_size   = '0;
               cursor     = 0;
            end
         end
      endcase
      if (reject) o.status = rsr_pkg::STATUS_REJECT;
      o.grew        = fresh;
      o.chosen_slot = rsr_pkg::CHOSEN_W'(chosen);
      if (!reject && chosen < MAX_SLOTS && slot_live[chosen]) begin
         o.slot_res_id = slot_owner[chosen];
         o.slot_offset = slot_addr[chosen];
      end
      o.active_slots = rsr_pkg::ACTIVE_W'(live_count);
      return o;
   endfunction

   function automatic rsr_pkg::req_type mk_req(input rsr_pkg::op_type op,
                                               input int unsigned idx,
                                               input logic [rsr_pkg::SEQ_W-1:0] seq,
                                               input int unsigned ring, input bit ok,
                                               input logic [rsr_pkg::RES_W-1:0] res,
                                               input logic [rsr_pkg::OFF_W-1:0] off);
      rsr_pkg::req_type r;
      r.opcode      = op;
      r.slot_index  = rsr_pkg::IDX_FIELD_W'(idx);
      r.seqno       = seq;
      r.ring_id     = rsr_pkg::RING_W'(ring);
      r.pool_ok     = ok;
      r.pool_res_id = res;
      r.pool_offset = off;
      return r;
   endfunction

   function automatic rsr_pkg::rsp_type rejected_rsp(input int unsigned active);
      rsr_pkg::rsp_type o;
      o              = '0;
      o.status       = rsr_pkg::STATUS_REJECT;
      o.active_slots = rsr_pkg::ACTIVE_W'(active);
      return o;
   endfunction

   // random request: mostly rotates and submits so the table fills and waits
   function automatic rsr_pkg::req_type random_req();
      rsr_pkg::req_type r;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 45)      r.opcode = rsr_pkg::OP_ROTATE;
      else if (pick < 77) r.opcode = rsr_pkg::OP_SUBMIT;
      else if (pick < 97) r.opcode = rsr_pkg::OP_ADD_SLOT;
      else                r.opcode = rsr_pkg::OP_RELEASE;
      if ($urandom_range(0, 99) < 85) begin
         r.slot_index = rsr_pkg::IDX_FIELD_W'($urandom_range(0, 7));
      end else begin
         r.slot_index = rsr_pkg::IDX_FIELD_W'($urandom_range(8, 15));
      end
      r.seqno       = $urandom;
      r.ring_id     = rsr_pkg::RING_W'($urandom_range(0, 15));
      r.pool_ok     = ($urandom_range(0, 9) < 7);
      r.pool_res_id = $urandom;
      r.pool_offset = $urandom;
      return r;
   endfunction

   // offer one request, hold it until the transfer, then log the expectation
   task automatic send_req(input rsr_pkg::req_type r, input bit fixed,
                           input rsr_pkg::rsp_type want);
      int unsigned gap;
      rsr_pkg::rsp_type guess;
      gap = quiet_phase ? 0 : $urandom_range(0, MAX_GAP);
      // valid stays high across back-to-back items
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data  <= r;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      // shadow runs even when the result is typed in, to keep its state
      guess = predict_slot_result(r);
      pending_rsp.push_back(fixed ? want : guess);
   endtask

   // size register write, only with the block idle
   task automatic write_size(input logic [rsr_pkg::SIZE_W-1:0] v);
      req_ch.valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.data  <= v;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
      cur_size = v;
   endtask

   // ---------------------------------------------------------------------
   // stimulus: directed table, then random phases
   // ---------------------------------------------------------------------
   initial begin : request_side
      step_row_type               steps [$];
      int unsigned                items_sent;
      int unsigned                phase_len;
      int unsigned                pick;
      logic [rsr_pkg::SIZE_W-1:0] sz;

      req_ch.valid = 1'b0;
      req_ch.data  = '0;
      csr_ch.valid = 1'b0;
      csr_ch.data  = '0;
      items_sent   = 0;

      // unconfigured ring, nothing in use yet
      steps.push_back(step_row_type'{1'b0, '0,
                                     mk_req(rsr_pkg::OP_ROTATE, 0, 0, 0, 1, 0, 0),
                                     1'b1, rejected_rsp(0)});
      steps.push_back(step_row_type'{1'b0, '0,
                                     mk_req(rsr_pkg::OP_ADD_SLOT, 3, 0, 0, 1, 5, 64),
                                     1'b1, rejected_rsp(0)});
      steps.push_back(step_row_type'{1'b0, '0,
                                     mk_req(rsr_pkg::OP_SUBMIT, 15, '1, 15, 1, '1, '1),
                                     1'b1, rejected_rsp(0)});
      // release on an empty table is a no-op
      steps.push_back(step_row_type'{1'b0, '0,
                                     mk_req(rsr_pkg::OP_RELEASE, 0, 0, 0, 0, 0, 0),
                                     1'b1, '0});
      // submit to an in-range slot that is not live still marks it in flight
      steps.push_back(step_row_type'{1'b0, '0,
                                     mk_req(rsr_pkg::OP_SUBMIT, 0, '1, 15, 0, 0, 0),
                                     1'b1, '0});
      // pool refused on an empty table: falls back to waiting on slot 0
      steps.push_back(step_row_type'{1'b1, SIZE_MIN,
                                     mk_req(rsr_pkg::OP_ROTATE, 0, 0, 0, 0, 0, 0),
                                     1'b0, '0});
      // first grow, all-ones grant
      steps.push_back(step_row_type'{1'b0, '0,
                                     mk_req(rsr_pkg::OP_ROTATE, 0, 0, 0, 1, '1, '1),
                                     1'b0, '0});
      steps.push_back(step_row_type'{1'b0, '0,
                                     mk_req(rsr_pkg::OP_ROTATE, 0, 0, 0, 1, 0, 0),
                                     1'b0, '0});
      steps.push_back(step_row_type'{1'b0, '0,
                                     mk_req(rsr_pkg::OP_SUBMIT, 0, 1, 0, 0, 0, 0),
                                     1'b0, '0});
      // next slot busy, grow by one
      steps.push_back(step_row_type'{1'b0, '0,
                                     mk_req(rsr_pkg::OP_ROTATE, 0, 0, 0, 1,
                                            32'h1111, 32'h40),
                                     1'b0, '0});
      // add past the end leaves a hole of skipped slots
      steps.push_back(step_row_type'{1'b0, '0,
                                     mk_req(rsr_pkg::OP_ADD_SLOT, 7, 0, 0, 1,
                                            32'h7777, 32'h1c0),
                                     1'b0, '0});
      // add on a live slot ignores the grant
      steps.push_back(step_row_type'{1'b0, '0,
                                     mk_req(rsr_pkg::OP_ADD_SLOT, 7, 0, 0, 1,
                                            32'hdead, 32'hbeef),
                                     1'b0, '0});
      steps.push_back(step_row_type'{1'b0, '0,
                                     mk_req(rsr_pkg::OP_ADD_SLOT, 5, 0, 0, 0, 0, 0),
                                     1'b0, '0});
      steps.push_back(step_row_type'{1'b0, '0,
                                     mk_req(rsr_pkg::OP_ADD_SLOT, 8, 0, 0, 1, 1, 1),
                                     1'b0, '0});
      // rotate onto a skipped slot, treated as free
      steps.push_back(step_row_type'{1'b1, SIZE_MAX,
                                     mk_req(rsr_pkg::OP_ROTATE, 0, 0, 0, 1, 0, 0),
                                     1'b0, '0});
      steps.push_back(step_row_type'{1'b0, '0,
                                     mk_req(rsr_pkg::OP_SUBMIT, 3, 32'h8000_0000, 5,
                                            0, 0, 0),
                                     1'b0, '0});
      // table at cap and next busy: wait with status ok
      steps.push_back(step_row_type'{1'b0, '0,
                                     mk_req(rsr_pkg::OP_ROTATE, 0, 0, 0, 1, 9, 9),
                                     1'b0, '0});
      steps.push_back(step_row_type'{1'b0, '0,
                                     mk_req(rsr_pkg::OP_ROTATE, 0, 0, 0, 0, 0, 0),
                                     1'b0, '0});
      steps.push_back(step_row_type'{1'b0, '0,
                                     mk_req(rsr_pkg::OP_SUBMIT, 8, 7, 3, 0, 0, 0),
                                     1'b0, '0});
      // size back to zero with slots in use
      steps.push_back(step_row_type'{1'b1, '0,
                                     mk_req(rsr_pkg::OP_ROTATE, 0, 0, 0, 1, 0, 0),
                                     1'b0, '0});
      steps.push_back(step_row_type'{1'b1, SIZE_MIN,
                                     mk_req(rsr_pkg::OP_SUBMIT, 7, 0, 15, 0, 0, 0),
                                     1'b0, '0});
      steps.push_back(step_row_type'{1'b0, '0,
                                     mk_req(rsr_pkg::OP_ROTATE, 0, 0, 0, 0, 0, 0),
                                     1'b0, '0});
      // release clears the slot table state, the size register included
      steps.push_back(step_row_type'{1'b0, '0,
                                     mk_req(rsr_pkg::OP_RELEASE, 0, 0, 0, 1, 0, 0),
                                     1'b1, '0});
      steps.push_back(step_row_type'{1'b0, '0,
                                     mk_req(rsr_pkg::OP_ROTATE, 0, 0, 0, 1, 4, 4),
                                     1'b1, rejected_rsp(0)});
      steps.push_back(step_row_type'{1'b0, '0,
                                     mk_req(rsr_pkg::OP_ADD_SLOT, 0, 0, 0, 1, 4, 4),
                                     1'b1, rejected_rsp(0)});

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (steps[i]) begin
         if (steps[i].load_size) write_size(steps[i].size_val);
         send_req(steps[i].req, steps[i].fixed, steps[i].rsp);
         items_sent++;
      end

      // random phases, each under its own slot size
      while (items_sent < steps.size() + RANDOM_ITEMS) begin
         pick = $urandom_range(0, 7);
         case (pick)
            0:       sz = SIZE_MIN;
            1:       sz = SIZE_MAX;
            2:       sz = '0;
            default: sz = rsr_pkg::SIZE_W'(64 * $urandom_range(1, 1048576));
         endcase
         write_size(sz);
         quiet_phase = ($urandom_range(0, 3) == 0);
         phase_len   = $urandom_range(20, 60);
         repeat (phase_len) begin
            send_req(random_req(), 1'b0, '0);
            items_sent++;
         end
      end

      // drain, then let the pipeline settle
      req_ch.valid <= 1'b0;
      quiet_phase = 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("rename_slot_ring_tb: done, clean");
      end else begin
         $display("rename_slot_ring_tb: done, errors");
      end
      $finish;
   end

   // ---------------------------------------------------------------------
   // response side: random stalls, one long hold-off, in-order compare
   // ---------------------------------------------------------------------
   initial begin : result_side
      int unsigned      stall;
      int unsigned      taken;
      rsr_pkg::rsp_type want;
      rsr_pkg::rsp_type got;

      rsp_ch.ready = 1'b0;
      taken        = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = quiet_phase ? 0 : $urandom_range(0, MAX_GAP);
         // long hold-off so the block backs up and stalls its input
         if (taken == HOLD_AT) stall = HOLD_CYCLES;
         if (stall != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
         got = rsp_ch.data;
         taken++;
         if (pending_rsp.size() == 0) begin
            error_count++;
            if (shown_count < SHOW_LIMIT) begin
               shown_count++;
               $display("result %0d: transfer with nothing expected", taken);
            end
         end else begin
            want = pending_rsp.pop_front();
            if (got.chosen_slot  !== want.chosen_slot  ||
                got.grew         !== want.grew         ||
                got.must_wait    !== want.must_wait    ||
                got.wait_seqno   !== want.wait_seqno   ||
                got.wait_ring    !== want.wait_ring    ||
                got.slot_res_id  !== want.slot_res_id  ||
                got.slot_offset  !== want.slot_offset  ||
                got.status       !== want.status       ||
                got.active_slots !== want.active_slots) begin
               error_count++;
               if (shown_count < SHOW_LIMIT) begin
                  shown_count++;
                  $display("result %0d mismatch", taken);
                  $display("  exp sl=%0d gr=%0b wt=%0b sq=%h rg=%0d rs=%h of=%h st=%0d ac=%0d",
                           want.chosen_slot, want.grew, want.must_wait, want.wait_seqno,
                           want.wait_ring, want.slot_res_id, want.slot_offset,
                           want.status, want.active_slots);
                  $display("  got sl=%0d gr=%0b wt=%0b sq=%h rg=%0d rs=%h of=%h st=%0d ac=%0d",
                           got.chosen_slot, got.grew, got.must_wait, got.wait_seqno,
                           got.wait_ring, got.slot_res_id, got.slot_offset,
                           got.status, got.active_slots);
               end
            end
         end
      end
   end

   // hang guard
   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("rename_slot_ring_tb: done, errors");
      $finish;
   end

endmodule
